// ----- rtl/lzwe_pkg.sv -----
// shared types and constants for the lzw variable width encoder
// no dependencies; imported by the front, back and top modules
package lzwe_pkg;

   localparam int MAX_WIDTH_DEF  = 12;
   localparam int HASH_SLOTS_DEF = 8192;
   localparam int START_WIDTH    = 9;
   localparam int EPOCH_W        = 8;
   localparam int CMD_DEPTH      = 2;
   localparam int RSP_DEPTH      = 4;

   localparam logic [11:0] CLR_CODE   = 12'd256;
   localparam logic [11:0] EOI_CODE   = 12'd257;
   localparam int          FIRST_FREE = 258;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [11:0] code;
      logic [3:0]  code_width;
      logic        run_end;
   } rsp_type;

   typedef enum logic {
      CMD_START,
      CMD_CONT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         last;
      logic [7:0]   data;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_HASH_MUL,
      ST_HASH_RED,
      ST_READ,
      ST_CHECK,
      ST_EMIT_START,
      ST_EMIT_MISS,
      ST_EMIT_WRAP,
      ST_EMIT_FLUSH,
      ST_EMIT_EOI
   } back_state_type;

endpackage

// ----- rtl/lzwe_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
module lzwe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lzwe_fifo.sv -----
// small register queue used between the front and back, and on the result side
// no dependencies; depth must be a power of two
module lzwe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/lzwe_front.sv -----
// front end: takes input items, classifies them into commands, queues them
// depends on lzwe_pkg and lzwe_fifo
module lzwe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lzwe_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output lzwe_pkg::cmd_type cmd_data
);
   import lzwe_pkg::*;

   cmd_type cmd_new;
   logic    q_full, q_empty;

   always_comb begin
      cmd_new.kind = req_data.first_byte ? CMD_START : CMD_CONT;
      cmd_new.last = req_data.last_byte;
      cmd_new.data = req_data.data_byte;
   end

   lzwe_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (cmd_new),
      .full      (q_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_data),
      .empty     (q_empty)
   );

   assign req_stall = q_full;
   assign cmd_valid = !q_empty;

endmodule

// ----- rtl/lzwe_back.sv -----
// back end: hashed dictionary lookup, code emission, width growth and restart
// depends on lzwe_pkg, lzwe_ram and lzwe_fifo
module lzwe_back #(
   parameter int MAX_WIDTH  = lzwe_pkg::MAX_WIDTH_DEF,
   parameter int HASH_SLOTS = lzwe_pkg::HASH_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  lzwe_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lzwe_pkg::rsp_type rsp_data
);
   import lzwe_pkg::*;

   localparam int CODE_W  = MAX_WIDTH;
   localparam int NFC_W   = MAX_WIDTH + 1;
   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int SLOT_W  = $clog2(HASH_SLOTS);
   localparam int CNT_W   = $clog2(HASH_SLOTS + 1);
   localparam int KEY_W   = MAX_WIDTH + 8;
   localparam int RSH     = KEY_W + SLOT_W;
   localparam int RECIP_W = KEY_W + 2;
   localparam int PROD_W  = KEY_W + RECIP_W;
   localparam int QW      = PROD_W - RSH;
   localparam int QN_W    = QW + SLOT_W + 1;
   localparam int ENT_W   = 1 + EPOCH_W + CODE_W + 8 + CODE_W;
   localparam longint unsigned RECIP =
      ((64'd1 << RSH) + 64'(HASH_SLOTS) - 64'd1) / 64'(HASH_SLOTS);
   localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);
   localparam logic [SLOT_W:0]    SLOTS_K = (SLOT_W + 1)'(HASH_SLOTS);
   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(HASH_SLOTS - 1);
   localparam logic [CNT_W-1:0]   LAST_PROBE = CNT_W'(HASH_SLOTS - 1);
   localparam logic [NFC_W-1:0]   FREE_K = NFC_W'(FIRST_FREE);
   localparam logic [WW-1:0]      START_K = WW'(START_WIDTH);
   localparam logic [WW-1:0]      MAX_K = WW'(MAX_WIDTH);

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [CODE_W-1:0]     prefix_ff, prefix_in;
   logic [NFC_W-1:0]      nfc_ff, nfc_in;
   logic [WW-1:0]         width_ff, width_in;
   logic [EPOCH_W-1:0]    epoch_ff, epoch_in;
   logic                  sweep_pend_ff, sweep_pend_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]      probe_ff, probe_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [CODE_W-1:0]     miss_code_ff, miss_code_in;
   logic [WW-1:0]         miss_width_ff, miss_width_in;
   logic                  wrap_ff, wrap_in;

   logic [KEY_W-1:0]      key;
   logic [QW-1:0]         quot;
   logic [QN_W-1:0]       quot_n;
   logic [KEY_W-1:0]      rem;
   logic [ENT_W-1:0]      rd_ent, wr_ent;
   logic                  wr_en;
   logic                  ent_used, ent_hit;
   logic [EPOCH_W-1:0]    ent_epoch;
   logic [CODE_W-1:0]     ent_prefix, ent_code;
   logic [7:0]            ent_byte;
   logic [NFC_W-1:0]      nfc_next;
   logic                  nfc_pow2;
   logic                  out_push, out_full, out_empty;
   rsp_type               out_item;
   logic                  slot_end;

   assign key      = {prefix_ff, cmd_ff.data};
   assign quot     = prod_ff[PROD_W-1 -: QW];
   assign quot_n   = {(SLOT_W + 1)'(0), quot} * {QW'(0), SLOTS_K};
   assign rem      = key - quot_n[KEY_W-1:0];
   assign slot_end = (slot_ff == LAST_SLOT);

   assign {ent_used, ent_epoch, ent_prefix, ent_byte, ent_code} = rd_ent;
   // a slot counts only if written in the current dictionary epoch
   assign ent_hit  = ent_used && (ent_epoch == epoch_ff);
   assign nfc_next = nfc_ff + NFC_W'(1);
   assign nfc_pow2 = ((nfc_next & (nfc_next - NFC_W'(1))) == '0);

   lzwe_ram #(
      .WIDTH (ENT_W),
      .DEPTH (HASH_SLOTS)
   ) u_dict (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_ent),
      .rd_addr (slot_ff),
      .rd_data (rd_ent)
   );

   lzwe_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .full      (out_full),
      .pop       (!rsp_stall),
      .pop_data  (rsp_data),
      .empty     (out_empty)
   );

   assign rsp_valid = !out_empty;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (slot_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (sweep_pend_ff) begin
               state_in = ST_SWEEP;
            end else if (cmd_valid) begin
               state_in = (cmd_data.kind == CMD_START) ? ST_EMIT_START : ST_HASH_MUL;
            end
         end
         ST_HASH_MUL: state_in = ST_HASH_RED;
         ST_HASH_RED: state_in = ST_READ;
         ST_READ:     state_in = ST_CHECK;
         ST_CHECK: begin
            if (ent_hit && ent_prefix == prefix_ff && ent_byte == cmd_ff.data) begin
               state_in = cmd_ff.last ? ST_EMIT_FLUSH : ST_IDLE;
            end else if (ent_hit && probe_ff != LAST_PROBE) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_EMIT_MISS;
            end
         end
         ST_EMIT_START: begin
            if (!out_full) begin
               state_in = cmd_ff.last ? ST_EMIT_FLUSH : ST_IDLE;
            end
         end
         ST_EMIT_MISS: begin
            if (!out_full) begin
               if (wrap_ff) begin
                  state_in = ST_EMIT_WRAP;
               end else begin
                  state_in = cmd_ff.last ? ST_EMIT_FLUSH : ST_IDLE;
               end
            end
         end
         ST_EMIT_WRAP: begin
            if (!out_full) begin
               state_in = cmd_ff.last ? ST_EMIT_FLUSH : ST_IDLE;
            end
         end
         ST_EMIT_FLUSH: begin
            if (!out_full) begin
               state_in = ST_EMIT_EOI;
            end
         end
         ST_EMIT_EOI: begin
            if (!out_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in        = cmd_ff;
      prefix_in     = prefix_ff;
      nfc_in        = nfc_ff;
      width_in      = width_ff;
      epoch_in      = epoch_ff;
      sweep_pend_in = sweep_pend_ff;
      slot_in       = slot_ff;
      probe_in      = probe_ff;
      prod_in       = prod_ff;
      miss_code_in  = miss_code_ff;
      miss_width_in = miss_width_ff;
      wrap_in       = wrap_ff;
      wr_en         = 1'b0;
      wr_ent        = '0;
      cmd_pop       = 1'b0;
      out_push      = 1'b0;
      out_item      = '0;
      case (state_ff)
         ST_SWEEP: begin
            wr_en   = 1'b1;
            slot_in = slot_end ? '0 : slot_ff + SLOT_W'(1);
            if (slot_end) begin
               sweep_pend_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (sweep_pend_ff) begin
               // clearing pass always starts from the bottom slot
               slot_in = '0;
            end else if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_data;
               probe_in = '0;
               if (cmd_data.kind == CMD_START) begin
                  nfc_in    = FREE_K;
                  width_in  = START_K;
                  epoch_in  = epoch_ff + EPOCH_W'(1);
                  prefix_in = CODE_W'(cmd_data.data);
                  if (&epoch_ff) begin
                     sweep_pend_in = 1'b1;
                  end
               end
            end
         end
         ST_HASH_MUL: begin
            prod_in = {RECIP_W'(0), key} * {KEY_W'(0), RECIP_K};
         end
         ST_HASH_RED: begin
            slot_in = rem[SLOT_W-1:0];
         end
         ST_CHECK: begin
            if (ent_hit && ent_prefix == prefix_ff && ent_byte == cmd_ff.data) begin
               prefix_in = ent_code;
            end else if (ent_hit && probe_ff != LAST_PROBE) begin
               slot_in  = slot_end ? '0 : slot_ff + SLOT_W'(1);
               probe_in = probe_ff + CNT_W'(1);
            end else begin
               // a full table still spends the code
               wr_en         = !ent_hit;
               wr_ent        = {1'b1, epoch_ff, prefix_ff, cmd_ff.data,
                                nfc_ff[CODE_W-1:0]};
               miss_code_in  = prefix_ff;
               miss_width_in = width_ff;
               prefix_in     = CODE_W'(cmd_ff.data);
               wrap_in       = 1'b0;
               nfc_in        = nfc_next;
               if (nfc_pow2) begin
                  if (width_ff < MAX_K) begin
                     width_in = width_ff + WW'(1);
                  end else begin
                     wrap_in  = 1'b1;
                     nfc_in   = FREE_K;
                     width_in = START_K;
                     epoch_in = epoch_ff + EPOCH_W'(1);
                     if (&epoch_ff) begin
                        sweep_pend_in = 1'b1;
                     end
                  end
               end
            end
         end
         ST_EMIT_START: begin
            out_push            = 1'b1;
            out_item.code       = CLR_CODE;
            out_item.code_width = 4'(START_WIDTH);
            out_item.run_end    = !cmd_ff.last;
         end
         ST_EMIT_MISS: begin
            out_push            = 1'b1;
            out_item.code       = 12'(miss_code_ff);
            out_item.code_width = 4'(miss_width_ff);
            out_item.run_end    = !wrap_ff && !cmd_ff.last;
         end
         ST_EMIT_WRAP: begin
            out_push            = 1'b1;
            out_item.code       = CLR_CODE;
            out_item.code_width = 4'(MAX_WIDTH);
            out_item.run_end    = !cmd_ff.last;
         end
         ST_EMIT_FLUSH: begin
            out_push            = 1'b1;
            out_item.code       = 12'(prefix_ff);
            out_item.code_width = 4'(width_ff);
            out_item.run_end    = 1'b0;
         end
         ST_EMIT_EOI: begin
            out_push            = 1'b1;
            out_item.code       = EOI_CODE;
            out_item.code_width = 4'(width_ff);
            out_item.run_end    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         prefix_ff     <= '0;
         nfc_ff        <= FREE_K;
         width_ff      <= START_K;
         epoch_ff      <= '0;
         sweep_pend_ff <= 1'b1;
         slot_ff       <= '0;
         probe_ff      <= '0;
         wrap_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prefix_ff     <= prefix_in;
         nfc_ff        <= nfc_in;
         width_ff      <= width_in;
         epoch_ff      <= epoch_in;
         sweep_pend_ff <= sweep_pend_in;
         slot_ff       <= slot_in;
         probe_ff      <= probe_in;
         wrap_ff       <= wrap_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      prod_ff       <= prod_in;
      miss_code_ff  <= miss_code_in;
      miss_width_ff <= miss_width_in;
   end

endmodule

// ----- rtl/lzw_variable_width_encoder_core.sv -----
// LZW encoder taking one byte per item and giving 9 to MAX_WIDTH bit codes.
// A byte that hits in the dictionary passes through the back end as queue
// pop, hash multiply, hash reduce, dictionary read and compare; each extra
// probe of the open-addressed table repeats the read and compare. After
// reset, and after every 256th dictionary restart, a clearing pass sweeps
// every slot of the dictionary memory; a two-entry command queue keeps taking
// bytes meanwhile. Depends on lzwe_pkg, lzwe_front, lzwe_back.
module lzw_variable_width_encoder_core #(
   parameter int MAX_WIDTH  = lzwe_pkg::MAX_WIDTH_DEF,
   parameter int HASH_SLOTS = lzwe_pkg::HASH_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lzwe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lzwe_pkg::rsp_type rsp_data
);
   import lzwe_pkg::*;

   cmd_type cmd_data;
   logic    cmd_valid, cmd_pop;

   lzwe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   lzwe_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .HASH_SLOTS (HASH_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
